// ----- rtl/sxf_pkg.sv -----
package sxf_pkg;

   localparam int SCREEN_WIDTH = 64;
   localparam int SCREEN_HEIGHT = 32;

   localparam int SPRITE_W = 8;
   localparam int PIXEL_X_W = 6;
   localparam int ROW_Y_W = 5;

   localparam int ROW_AW = $clog2(SCREEN_HEIGHT);
   localparam int COL_AW = $clog2(SCREEN_WIDTH);
   localparam int ROW_Y_EXT_W = ROW_Y_W + ROW_AW;
   localparam int COL_SUM_W = PIXEL_X_W + COL_AW;

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic operation;
      logic [PIXEL_X_W-1:0] pixel_x;
      logic [ROW_Y_W-1:0] row_y;
      logic [SPRITE_W-1:0] sprite_row;
      logic first_row;
      logic last_row;
   } sxf_req_type;

   typedef struct packed {
      logic [SPRITE_W-1:0] screen_pixels;
      logic collision;
      logic sprite_done;
   } sxf_rsp_type;

   typedef struct packed {
      logic load;
      logic commit;
   } sxf_cmd_type;

endpackage

// ----- rtl/sprite_xor_framebuffer.sv -----
// Monochrome sprite framebuffer with XOR drawing and collision detection.
// A request on the req_ channel either clears the whole screen or XORs one
// eight-pixel sprite row into the stored bitmap at a column and screen row.
// Every request returns exactly one response on the rsp_ channel with the
// eight updated screen pixels at that place, the sticky collision flag and
// an echo of the last-row flag, or all zeros for a clear. Pixels past the
// right or bottom edge are clipped and read back as zero.
// A request is accepted when req_valid is high and req_stall is low, and a
// response is taken when rsp_valid is high and rsp_stall is low.
// Each request is done in order: a registered read of its screen row from
// the frame memory, then the XOR, the row write-back and the load of the
// response register. req_stall stays high until that last step is done.
// The response appears in the cycle after the write-back. While a response
// is stalled, the next request is still accepted and its row is read, but
// its write-back waits until the response register is free.
// A synchronous reset clears the screen at once through per-row valid bits,
// clears the collision flag and drops any pending response. A clear command
// goes through the same read and commit steps as a sprite row.
module sprite_xor_framebuffer import sxf_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input sxf_req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output sxf_rsp_type rsp_data
);

   sxf_cmd_type cmd;

   sxf_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd(cmd)
   );

   sxf_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .req_data(req_data),
      .rsp_data(rsp_data)
   );

endmodule

// ----- rtl/sxf_ram.sv -----
module sxf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic wen,
   input logic [$clog2(DEPTH)-1:0] waddr,
   input logic [WIDTH-1:0] wdata,
   input logic ren,
   input logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/sxf_ctrl.sv -----
module sxf_ctrl import sxf_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input logic rsp_stall,
   output sxf_cmd_type cmd
);

   typedef enum logic {
      IDLE,
      BUSY
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      cmd.load = 1'b0;
      cmd.commit = 1'b0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = BUSY;
            end
         end
         BUSY: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("Result register overwritten while a response is stalled.");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Controller did not go busy after accepting a request.");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (rsp_valid && !req_stall))
      else $error("Committed request did not produce a response.");

endmodule

// ----- rtl/sxf_datapath.sv -----
module sxf_datapath import sxf_pkg::*; (
   input logic clock,
   input logic reset,
   input sxf_cmd_type cmd,
   input sxf_req_type req_data,
   output sxf_rsp_type rsp_data
);

   sxf_req_type req_ff;
   sxf_rsp_type rsp_ff;
   logic [SCREEN_HEIGHT-1:0] row_valid_ff;
   logic collision_ff;

   logic [ROW_Y_EXT_W-1:0] req_y_ext;
   logic [ROW_Y_EXT_W-1:0] cur_y_ext;
   logic [ROW_AW-1:0] req_addr;
   logic [ROW_AW-1:0] cur_addr;
   logic row_in_range;
   logic [SCREEN_WIDTH-1:0] ram_rdata;
   logic [SCREEN_WIDTH-1:0] old_row;
   logic [SCREEN_WIDTH-1:0] new_row;
   logic [SCREEN_WIDTH-1:0] sprite_mask;
   logic [SPRITE_W-1:0] shown;
   logic collision_in;
   logic ram_wen;

   assign req_y_ext = ROW_Y_EXT_W'(req_data.row_y);
   assign cur_y_ext = ROW_Y_EXT_W'(req_ff.row_y);
   assign req_addr = req_y_ext[ROW_AW-1:0];
   assign cur_addr = cur_y_ext[ROW_AW-1:0];
   assign row_in_range = cur_y_ext < ROW_Y_EXT_W'(SCREEN_HEIGHT);

   sxf_ram #(
      .WIDTH(SCREEN_WIDTH),
      .DEPTH(SCREEN_HEIGHT)
   ) u_frame_ram (
      .clock(clock),
      .wen(ram_wen),
      .waddr(cur_addr),
      .wdata(new_row),
      .ren(cmd.load),
      .raddr(req_addr),
      .rdata(ram_rdata)
   );

   assign old_row = row_valid_ff[cur_addr] ? ram_rdata : '0;

   always_comb begin
      logic [COL_SUM_W-1:0] col_sum;
      sprite_mask = '0;
      for (int i = 0; i < SPRITE_W; i++) begin
         col_sum = COL_SUM_W'(req_ff.pixel_x) + COL_SUM_W'(i);
         if ((col_sum < COL_SUM_W'(SCREEN_WIDTH)) && req_ff.sprite_row[SPRITE_W-1-i]) begin
            sprite_mask[col_sum[COL_AW-1:0]] = 1'b1;
         end
      end
   end

   assign new_row = old_row ^ sprite_mask;

   always_comb begin
      logic [COL_SUM_W-1:0] col_sum;
      shown = '0;
      for (int i = 0; i < SPRITE_W; i++) begin
         col_sum = COL_SUM_W'(req_ff.pixel_x) + COL_SUM_W'(i);
         if ((col_sum < COL_SUM_W'(SCREEN_WIDTH)) && row_in_range) begin
            shown[SPRITE_W-1-i] = new_row[col_sum[COL_AW-1:0]];
         end
      end
   end

   always_comb begin
      collision_in = req_ff.first_row ? 1'b0 : collision_ff;
      if (row_in_range && (|(old_row & sprite_mask))) begin
         collision_in = 1'b1;
      end
   end

   assign ram_wen = cmd.commit && (req_ff.operation == OP_DRAW) && row_in_range;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         if (req_ff.operation == OP_CLEAR) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.screen_pixels <= shown;
            rsp_ff.collision <= collision_in;
            rsp_ff.sprite_done <= req_ff.last_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         collision_ff <= 1'b0;
      end else if (cmd.commit) begin
         if (req_ff.operation == OP_CLEAR) begin
            row_valid_ff <= '0;
            collision_ff <= 1'b0;
         end else begin
            collision_ff <= collision_in;
            if (row_in_range) begin
               row_valid_ff[cur_addr] <= 1'b1;
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

   a_clear_drops_collision: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (req_ff.operation == OP_CLEAR)) |=> (!collision_ff && (row_valid_ff == '0)))
      else $error("Clear command left screen rows or collision set.");

endmodule

// ----- bench/sprite_xor_framebuffer_tb.sv -----
import sxf_pkg::*;

class xor_screen_scoreboard;
   bit [SCREEN_WIDTH-1:0] lit_rows [SCREEN_HEIGHT];
   bit collision_flag;
   sxf_rsp_type awaited_responses[$];
   int errors;

   function void apply_request(sxf_req_type r);
      sxf_rsp_type want;
      int col;
      want = '0;
      if (r.operation == OP_CLEAR) begin
         foreach (lit_rows[i]) lit_rows[i] = '0;
         collision_flag = 1'b0;
      end else begin
         if (r.first_row) collision_flag = 1'b0;
         if (r.row_y < SCREEN_HEIGHT) begin
            for (int i = 0; i < SPRITE_W; i++) begin
               col = int'(r.pixel_x) + i;
               if (col < SCREEN_WIDTH) begin
                  if (r.sprite_row[SPRITE_W-1-i]) begin
                     if (lit_rows[r.row_y][col]) collision_flag = 1'b1;
                     lit_rows[r.row_y][col] = ~lit_rows[r.row_y][col];
                  end
                  want.screen_pixels[SPRITE_W-1-i] = lit_rows[r.row_y][col];
               end
            end
         end
         want.collision = collision_flag;
         want.sprite_done = r.last_row;
      end
      awaited_responses.push_back(want);
   endfunction

   function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   function void check_response(sxf_rsp_type got);
      sxf_rsp_type want;
      if (awaited_responses.size() == 0) begin
         $display("%0t: response expected none, got %0h", $time, got);
         errors++;
         return;
      end
      want = awaited_responses.pop_front();
      compare_field("screen_pixels", want.screen_pixels, got.screen_pixels);
      compare_field("collision", 8'(want.collision), 8'(got.collision));
      compare_field("sprite_done", 8'(want.sprite_done), 8'(got.sprite_done));
   endfunction
endclass

module sprite_xor_framebuffer_tb;
   localparam int ITEM_COUNT = 600;
   localparam int IDLE_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sxf_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sxf_rsp_type rsp_data;

   xor_screen_scoreboard sb = new;
   int sent = 0;
   int rsp_count = 0;

   sprite_xor_framebuffer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.apply_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
         rsp_count++;
      end
   end

   function automatic sxf_req_type make_request(logic op, logic [PIXEL_X_W-1:0] x,
                                                logic [ROW_Y_W-1:0] y, logic [SPRITE_W-1:0] spr,
                                                logic first, logic last);
      sxf_req_type r;
      r.operation = op;
      r.pixel_x = x;
      r.row_y = y;
      r.sprite_row = spr;
      r.first_row = first;
      r.last_row = last;
      return r;
   endfunction

   task automatic send_request(input sxf_req_type r);
      while ((sent < 250 || sent >= 370) && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic random_sprite(input bit drop_first);
      int x;
      int y;
      int lines;
      lines = $urandom_range(1, 15);
      case ($urandom_range(3))
         0, 1: begin
            x = $urandom_range(0, 15);
            y = $urandom_range(0, 7);
         end
         2: begin
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 31);
         end
         default: begin
            x = $urandom_range(50, 63);
            y = $urandom_range(20, 31);
         end
      endcase
      for (int l = 0; l < lines; l++) begin
         send_request(make_request(OP_DRAW, PIXEL_X_W'(x), ROW_Y_W'(y + l),
                                   SPRITE_W'($urandom_range(255)),
                                   (l == 0) && !drop_first,
                                   drop_first ? 1'($urandom_range(1)) : (l == lines - 1)));
      end
   endtask

   initial begin : receiver
      int hold;
      bit held_once;
      hold = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_once && rsp_count >= 80) begin
            held_once = 1'b1;
            hold = 60;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (rsp_count >= 250 && rsp_count < 370) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 18);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("sprite_xor_framebuffer: mismatch");
      $finish;
   end

   initial begin : stimulus
      bit paused;
      int roll;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The clear command ignores all its other fields.
      send_request(make_request(OP_CLEAR, 6'd63, 5'd31, 8'hFF, 1'b1, 1'b1));
      send_request(make_request(OP_DRAW, 6'd0, 5'd0, 8'hFF, 1'b1, 1'b1));
      send_request(make_request(OP_DRAW, 6'd0, 5'd0, 8'hFF, 1'b1, 1'b1));
      send_request(make_request(OP_DRAW, 6'd0, 5'd0, 8'h00, 1'b1, 1'b1));
      send_request(make_request(OP_DRAW, 6'd63, 5'd31, 8'hFF, 1'b1, 1'b1));
      send_request(make_request(OP_DRAW, 6'd60, 5'd31, 8'hFF, 1'b1, 1'b1));
      send_request(make_request(OP_DRAW, 6'd57, 5'd31, 8'hAA, 1'b1, 1'b0));
      send_request(make_request(OP_DRAW, 6'd56, 5'd30, 8'h55, 1'b0, 1'b1));
      send_request(make_request(OP_DRAW, 6'd10, 5'd5, 8'h3C, 1'b1, 1'b0));
      send_request(make_request(OP_DRAW, 6'd10, 5'd6, 8'h42, 1'b0, 1'b0));
      send_request(make_request(OP_DRAW, 6'd10, 5'd7, 8'h81, 1'b0, 1'b0));
      send_request(make_request(OP_DRAW, 6'd10, 5'd8, 8'hFF, 1'b0, 1'b1));
      // A collision in a middle row stays set through the last row.
      send_request(make_request(OP_DRAW, 6'd10, 5'd4, 8'hFF, 1'b1, 1'b0));
      send_request(make_request(OP_DRAW, 6'd10, 5'd6, 8'h40, 1'b0, 1'b0));
      send_request(make_request(OP_DRAW, 6'd10, 5'd9, 8'h18, 1'b0, 1'b0));
      send_request(make_request(OP_DRAW, 6'd10, 5'd10, 8'h00, 1'b0, 1'b1));
      send_request(make_request(OP_DRAW, 6'd11, 5'd7, 8'h80, 1'b0, 1'b0));
      send_request(make_request(OP_CLEAR, 6'd0, 5'd0, 8'h00, 1'b0, 1'b0));
      send_request(make_request(OP_DRAW, 6'd10, 5'd5, 8'h3C, 1'b1, 1'b1));
      send_request(make_request(OP_DRAW, 6'd0, 5'd0, 8'h80, 1'b0, 1'b0));
      send_request(make_request(OP_DRAW, 6'd63, 5'd0, 8'h01, 1'b1, 1'b1));
      send_request(make_request(OP_DRAW, 6'd31, 5'd16, 8'hC3, 1'b1, 1'b1));

      while (sent < ITEM_COUNT) begin
         if (!paused && sent >= 450) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (rsp_count != sent) @(posedge clock);
         end
         roll = $urandom_range(99);
         if (roll < 75) begin
            random_sprite(1'b0);
         end else if (roll < 90) begin
            send_request(make_request($urandom_range(15) == 0,
                                      PIXEL_X_W'($urandom_range(63)),
                                      ROW_Y_W'($urandom_range(31)),
                                      SPRITE_W'($urandom_range(255)),
                                      1'($urandom_range(1)), 1'($urandom_range(1))));
         end else begin
            random_sprite(1'b1);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_count != sent) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.awaited_responses.size() != 0) begin
         $display("%0t: %0d responses expected, got none", $time,
                  sb.awaited_responses.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("sprite_xor_framebuffer: match");
      end else begin
         $display("sprite_xor_framebuffer: mismatch");
      end
      $finish;
   end
endmodule
